// ----- design/gti_pkg.sv -----
// ----------------------------------------------------------------------------
// gti_pkg
// Shared types and constants for the grid trilinear interpolator.
// ----------------------------------------------------------------------------
package gti_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int STORE_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // per-axis weight, corner weight and accumulator widths
    localparam int W_W      = FRAC_W + 1;
    localparam int WT_W     = 3 * FRAC_W + 1;
    localparam int WT_SPLIT = 24;
    localparam int ACC_W    = DATA_W + WT_W - 1;

    localparam logic [W_W-1:0] ONE_Q16 = W_W'(32'h0001_0000);

    localparam int NUM_AXES  = 3;
    localparam int CORNERS   = 8;
    localparam int CNT_W     = $clog2(CORNERS);
    localparam int CFG_IDX_W = 3;

    localparam int DEF_SIZE_X = 32;
    localparam int DEF_SIZE_Y = 32;
    localparam int DEF_SIZE_Z = 32;

    localparam logic [DATA_W-1:0] ORIGIN_RESET   = '0;
    localparam logic [DATA_W-1:0] INV_STEP_RESET = 32'h0001_0000;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_INV_STEP_X = 3'd3,
        REG_INV_STEP_Y = 3'd4,
        REG_INV_STEP_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MAP_WAIT,
        ST_CORNER,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             write_entry;
        logic             start;
        logic             map_issue;
        axis_t            map_axis;
        logic             corner_issue;
        logic [CNT_W-1:0] corner;
        logic             out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic map_busy;
        logic acc_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/gti_ram.sv -----
// ----------------------------------------------------------------------------
// gti_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/gti_ctrl.sv -----
// ----------------------------------------------------------------------------
// gti_ctrl
// Sequencer: axis mapping passes, eight corner reads, drain, result hand-off.
// ----------------------------------------------------------------------------
module gti_ctrl
    import gti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       cmd,
    input  dp_status_t dp_status,
    output logic       in_stall,
    output ctl_cmd_t   ctl_cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid && (cmd == CMD_QUERY))
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                if (cnt_reg == CNT_W'(NUM_AXES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MAP_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAP_WAIT:
            begin
                if (!dp_status.map_busy)
                begin
                    state_next = ST_CORNER;
                end
            end
            ST_CORNER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORNERS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_status.acc_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl_cmd  = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall            = 1'b0;
                ctl_cmd.write_entry = in_valid && (cmd == CMD_WRITE);
                ctl_cmd.start       = in_valid && (cmd == CMD_QUERY);
            end
            ST_MAP:
            begin
                ctl_cmd.map_issue = 1'b1;
                ctl_cmd.map_axis  = axis_t'(cnt_reg[1:0]);
            end
            ST_CORNER:
            begin
                ctl_cmd.corner_issue = 1'b1;
                ctl_cmd.corner       = cnt_reg;
            end
            ST_DONE:
            begin
                ctl_cmd.out_load = dp_status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- design/gti_datapath.sv -----
// ----------------------------------------------------------------------------
// gti_datapath
// Config registers, axis mapper, grid memory, corner weight and blend pipeline.
// ----------------------------------------------------------------------------
module gti_datapath
    import gti_pkg::*;
#(
    parameter int SIZE_X = DEF_SIZE_X,
    parameter int SIZE_Y = DEF_SIZE_Y,
    parameter int SIZE_Z = DEF_SIZE_Z
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic [ADDR_W-1:0]        entry_address,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] coord_x,
    input  logic signed [DATA_W-1:0] coord_y,
    input  logic signed [DATA_W-1:0] coord_z,
    input  logic                     out_stall,
    input  ctl_cmd_t                 ctl_cmd,
    output dp_status_t               dp_status,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] value,
    output logic                     clamped
);

    localparam int MAX_XY   = (SIZE_X > SIZE_Y) ? SIZE_X : SIZE_Y;
    localparam int MAX_SIZE = (MAX_XY > SIZE_Z) ? MAX_XY : SIZE_Z;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int PROD_W   = 2 * DATA_W;
    localparam int PLO_W    = DATA_W + WT_SPLIT + 1;
    localparam int PHI_W    = DATA_W + (WT_W - WT_SPLIT) + 1;

    localparam logic [DATA_W-1:0] STRIDE_X = DATA_W'(SIZE_Y * SIZE_Z);
    localparam logic [DATA_W-1:0] STRIDE_Y = DATA_W'(SIZE_Z);
    localparam logic [DATA_W-1:0] STRIDE_Z = DATA_W'(1);

    localparam logic [ACC_W-1:0] ROUND_INIT = ACC_W'(1) << (3 * FRAC_W - 1);

    // configuration
    logic [DATA_W-1:0] origin_reg [NUM_AXES];
    logic [DATA_W-1:0] inv_reg    [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                origin_reg[i] <= ORIGIN_RESET;
                inv_reg[i]    <= INV_STEP_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:   origin_reg[AXIS_X] <= cfg_data;
                REG_ORIGIN_Y:   origin_reg[AXIS_Y] <= cfg_data;
                REG_ORIGIN_Z:   origin_reg[AXIS_Z] <= cfg_data;
                REG_INV_STEP_X: inv_reg[AXIS_X]    <= cfg_data;
                REG_INV_STEP_Y: inv_reg[AXIS_Y]    <= cfg_data;
                REG_INV_STEP_Z: inv_reg[AXIS_Z]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // query point, held for the mapping passes
    logic [DATA_W-1:0] coord_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.start)
        begin
            coord_reg[AXIS_X] <= coord_x;
            coord_reg[AXIS_Y] <= coord_y;
            coord_reg[AXIS_Z] <= coord_z;
        end
    end

    // mapper stage 1: offset from origin, exact 33-bit difference
    logic [DATA_W:0] m1_diff;

    assign m1_diff = {coord_reg[ctl_cmd.map_axis][DATA_W-1], coord_reg[ctl_cmd.map_axis]}
                   - {origin_reg[ctl_cmd.map_axis][DATA_W-1], origin_reg[ctl_cmd.map_axis]};

    logic              m2_valid_reg;
    axis_t             m2_axis_reg;
    logic              m2_neg_reg;
    logic [DATA_W-1:0] m2_d_reg;
    logic [DATA_W-1:0] m2_inv_reg;

    // mapper stage 2: grid position, Q32.32
    logic              m3_valid_reg;
    axis_t             m3_axis_reg;
    logic              m3_neg_reg;
    logic              m3_inv_nz_reg;
    logic [PROD_W-1:0] m3_prod_reg;
    logic [PROD_W-1:0] m3_prod_next;

    assign m3_prod_next = PROD_W'(m2_d_reg) * PROD_W'(m2_inv_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= ctl_cmd.map_issue;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_axis_reg   <= ctl_cmd.map_axis;
        m2_neg_reg    <= m1_diff[DATA_W];
        m2_d_reg      <= m1_diff[DATA_W-1:0];
        m2_inv_reg    <= inv_reg[ctl_cmd.map_axis];
        m3_axis_reg   <= m2_axis_reg;
        m3_neg_reg    <= m2_neg_reg;
        m3_inv_nz_reg <= (m2_inv_reg != '0);
        m3_prod_reg   <= m3_prod_next;
    end

    // mapper stage 3: clamp, split into index and fraction, address terms
    logic [DATA_W-1:0] m3_size;
    logic [IDX_W-1:0]  m3_last;
    logic [DATA_W-1:0] m3_ipart;
    logic [IDX_W-1:0]  m3_lo;
    logic [IDX_W-1:0]  m3_hi;
    logic [FRAC_W-1:0] m3_frac;
    logic              m3_clamp;
    logic [DATA_W-1:0] m3_lo_prod;
    logic [DATA_W-1:0] m3_hi_prod;

    assign m3_ipart = m3_prod_reg[PROD_W-1:DATA_W];

    always_comb
    begin
        unique case (m3_axis_reg)
            AXIS_X:
            begin
                m3_size = DATA_W'(SIZE_X);
                m3_last = IDX_W'(SIZE_X - 1);
            end
            AXIS_Y:
            begin
                m3_size = DATA_W'(SIZE_Y);
                m3_last = IDX_W'(SIZE_Y - 1);
            end
            AXIS_Z:
            begin
                m3_size = DATA_W'(SIZE_Z);
                m3_last = IDX_W'(SIZE_Z - 1);
            end
            default:
            begin
                m3_size = DATA_W'(SIZE_X);
                m3_last = IDX_W'(SIZE_X - 1);
            end
        endcase

        if (m3_neg_reg)
        begin
            // below the origin; a zero step never counts as clamped
            m3_lo    = '0;
            m3_frac  = '0;
            m3_clamp = m3_inv_nz_reg;
        end
        else if (m3_ipart >= m3_size)
        begin
            m3_lo    = m3_last;
            m3_frac  = '0;
            m3_clamp = 1'b1;
        end
        else
        begin
            m3_lo    = m3_ipart[IDX_W-1:0];
            m3_frac  = m3_prod_reg[DATA_W-1:DATA_W-FRAC_W];
            m3_clamp = 1'b0;
        end

        // upper corner stays on the last cell
        m3_hi = (m3_lo == m3_last) ? m3_lo : m3_lo + 1'b1;

        unique case (m3_axis_reg)
            AXIS_X:
            begin
                m3_lo_prod = {{(DATA_W-IDX_W){1'b0}}, m3_lo} * STRIDE_X;
                m3_hi_prod = {{(DATA_W-IDX_W){1'b0}}, m3_hi} * STRIDE_X;
            end
            AXIS_Y:
            begin
                m3_lo_prod = {{(DATA_W-IDX_W){1'b0}}, m3_lo} * STRIDE_Y;
                m3_hi_prod = {{(DATA_W-IDX_W){1'b0}}, m3_hi} * STRIDE_Y;
            end
            default:
            begin
                m3_lo_prod = {{(DATA_W-IDX_W){1'b0}}, m3_lo} * STRIDE_Z;
                m3_hi_prod = {{(DATA_W-IDX_W){1'b0}}, m3_hi} * STRIDE_Z;
            end
        endcase
    end

    logic [ADDR_W-1:0] lo_term_reg [NUM_AXES];
    logic [ADDR_W-1:0] hi_term_reg [NUM_AXES];
    logic [W_W-1:0]    wlo_reg     [NUM_AXES];
    logic [W_W-1:0]    whi_reg     [NUM_AXES];
    logic              clamp_reg;

    always_ff @(posedge clk)
    begin
        if (m3_valid_reg)
        begin
            lo_term_reg[m3_axis_reg] <= m3_lo_prod[ADDR_W-1:0];
            hi_term_reg[m3_axis_reg] <= m3_hi_prod[ADDR_W-1:0];
            wlo_reg[m3_axis_reg]     <= ONE_Q16 - {1'b0, m3_frac};
            whi_reg[m3_axis_reg]     <= {1'b0, m3_frac};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= 1'b0;
        end
        else if (ctl_cmd.start)
        begin
            clamp_reg <= 1'b0;
        end
        else if (m3_valid_reg && m3_clamp)
        begin
            clamp_reg <= 1'b1;
        end
    end

    // corner issue: address, x*y weight
    logic [CNT_W-1:0]  k;
    logic [ADDR_W-1:0] corner_addr;
    logic [W_W-1:0]    wx;
    logic [W_W-1:0]    wy;
    logic [W_W-1:0]    wz;
    logic [2*W_W-1:0]  wxy_next;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    assign k           = ctl_cmd.corner;
    assign corner_addr = (k[0] ? hi_term_reg[AXIS_X] : lo_term_reg[AXIS_X])
                       + (k[1] ? hi_term_reg[AXIS_Y] : lo_term_reg[AXIS_Y])
                       + (k[2] ? hi_term_reg[AXIS_Z] : lo_term_reg[AXIS_Z]);
    assign wx          = k[0] ? whi_reg[AXIS_X] : wlo_reg[AXIS_X];
    assign wy          = k[1] ? whi_reg[AXIS_Y] : wlo_reg[AXIS_Y];
    assign wz          = k[2] ? whi_reg[AXIS_Z] : wlo_reg[AXIS_Z];
    assign wxy_next    = (2*W_W)'(wx) * (2*W_W)'(wy);
    assign ram_addr    = ctl_cmd.write_entry ? entry_address : corner_addr;

    gti_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl_cmd.write_entry),
        .addr  (ram_addr),
        .wdata (entry_value),
        .rdata (ram_rdata)
    );

    // blend pipeline
    logic                    b_valid_reg;
    logic [2*W_W-1:0]        b_wxy_reg;
    logic [W_W-1:0]          b_wz_reg;
    logic [3*W_W-1:0]        wt_full;

    logic                    c_valid_reg;
    logic [WT_W-1:0]         c_wt_reg;
    logic signed [DATA_W-1:0] c_val_reg;
    logic signed [PLO_W-1:0] d_plo_next;
    logic signed [PHI_W-1:0] d_phi_next;

    logic                    d_valid_reg;
    logic signed [PLO_W-1:0] d_plo_reg;
    logic signed [PHI_W-1:0] d_phi_reg;
    logic signed [ACC_W-1:0] e_sum_next;

    logic                    e_valid_reg;
    logic signed [ACC_W-1:0] e_sum_reg;
    logic [ACC_W-1:0]        acc_reg;

    assign wt_full    = (3*W_W)'(b_wxy_reg) * (3*W_W)'(b_wz_reg);
    // value times weight in two partial products, low and high weight bits
    assign d_plo_next = PLO_W'(c_val_reg)
                      * PLO_W'($signed({1'b0, c_wt_reg[WT_SPLIT-1:0]}));
    assign d_phi_next = PHI_W'(c_val_reg)
                      * PHI_W'($signed({1'b0, c_wt_reg[WT_W-1:WT_SPLIT]}));
    assign e_sum_next = (ACC_W'(d_phi_reg) <<< WT_SPLIT) + ACC_W'(d_plo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= ctl_cmd.corner_issue;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_wxy_reg <= wxy_next;
        b_wz_reg  <= wz;
        c_wt_reg  <= wt_full[WT_W-1:0];
        c_val_reg <= ram_rdata;
        d_plo_reg <= d_plo_next;
        d_phi_reg <= d_phi_next;
        e_sum_reg <= e_sum_next;
    end

    // accumulator starts at one half lsb of the result for rounding
    always_ff @(posedge clk)
    begin
        if (ctl_cmd.start)
        begin
            acc_reg <= ROUND_INIT;
        end
        else if (e_valid_reg)
        begin
            acc_reg <= acc_reg + e_sum_reg;
        end
    end

    // result register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     clamped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl_cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.out_load)
        begin
            value_reg   <= acc_reg[ACC_W-1:ACC_W-DATA_W];
            clamped_reg <= clamp_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign clamped   = clamped_reg;

    assign dp_status.map_busy = m2_valid_reg | m3_valid_reg;
    assign dp_status.acc_busy = b_valid_reg | c_valid_reg | d_valid_reg | e_valid_reg;
    assign dp_status.out_free = !out_valid_reg || !out_stall;

endmodule

// ----- design/grid_trilinear_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// grid_trilinear_interpolator_top: trilinear lookup in a stored 3-D grid
// Write item: taken in idle, no result. Query: the input stalls until the
// result is loaded into the result register; set by three passes through the
// shared position multiplier and eight corner reads from the single-port grid.
// Reset clears control and config; grid contents are undefined until written.
// ----------------------------------------------------------------------------
module grid_trilinear_interpolator_top
    import gti_pkg::*;
#(
    parameter int SIZE_X = DEF_SIZE_X,
    parameter int SIZE_Y = DEF_SIZE_Y,
    parameter int SIZE_Z = DEF_SIZE_Z
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic [ADDR_W-1:0]        entry_address,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic signed [DATA_W-1:0] coord_x,
    input  logic signed [DATA_W-1:0] coord_y,
    input  logic signed [DATA_W-1:0] coord_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] value,
    output logic                     clamped
);

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_status;

    gti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .dp_status (dp_status),
        .in_stall  (in_stall),
        .ctl_cmd   (ctl_cmd)
    );

    gti_datapath #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .out_stall     (out_stall),
        .ctl_cmd       (ctl_cmd),
        .dp_status     (dp_status),
        .out_valid     (out_valid),
        .value         (value),
        .clamped       (clamped)
    );

    // a query transfer makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd == CMD_QUERY)) |=> in_stall)
        else $error("query transfer did not start the sequence");

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl_cmd.write_entry, ctl_cmd.start, ctl_cmd.map_issue,
                  ctl_cmd.corner_issue, ctl_cmd.out_load}))
        else $error("conflicting datapath commands");

    // result register is never overwritten while it holds an untaken result
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result loaded over a pending result");

    // new items are taken only with the pipelines empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(dp_status.map_busy || dp_status.acc_busy))
        else $error("input open while pipeline busy");

endmodule

// ----- dv/grid_trilinear_interpolator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_trilinear_interpolator_top_tb
// Self-checking bench for the grid trilinear interpolator. Grid loads and
// lookups go in over the valid/stall input channel. A local fixed-point model
// of the axis mapping and the corner blend predicts each lookup result.
// Every corner is loaded before any lookup reads it. The output side stalls
// at random, and once holds off long enough that the block backs up.
// ----------------------------------------------------------------------------
module grid_trilinear_interpolator_top_tb;
    import gti_pkg::*;

    localparam int GX            = DEF_SIZE_X;
    localparam int GY            = DEF_SIZE_Y;
    localparam int GZ            = DEF_SIZE_Z;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int DRAIN_LIMIT   = 5_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_PRINTS    = 200;

    typedef struct packed {
        logic [DATA_W-1:0] interp;
        logic              clip;
    } lookup_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     cmd;
    logic [ADDR_W-1:0]        entry_address;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] value;
    logic                     clamped;

    // local copy of the grid and of the registers
    logic [DATA_W-1:0] grid_model [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    logic [DATA_W-1:0] origin_q [NUM_AXES];
    logic [DATA_W-1:0] inv_step_q [NUM_AXES];

    lookup_result_t expected_lookups [$];
    int             mismatch_count = 0;
    int             items_sent = 0;
    int             cycle_count = 0;
    bit             idle_on = 1'b1;
    int             hold_token = 0;
    int             hold_served = 0;

    grid_trilinear_interpolator_top #(
        .SIZE_X (GX),
        .SIZE_Y (GY),
        .SIZE_Z (GZ)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .clamped       (clamped)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("grid_trilinear_interpolator_top_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // lookup model
    // ------------------------------------------------------------------------
    function automatic int unsigned axis_extent(input int k);
        case (k)
            0:       return GX;
            1:       return GY;
            default: return GZ;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] grid_index(input int unsigned x, y, z);
        int unsigned lin;
        lin = (x * GY + y) * GZ + z;
        return lin[ADDR_W-1:0];
    endfunction

    function automatic void map_query(input logic [DATA_W-1:0] cx, cy, cz,
                                      output logic [ADDR_W-1:0] addr [CORNERS],
                                      output logic [63:0] wt [CORNERS],
                                      output bit clip);
        logic [DATA_W-1:0] c [NUM_AXES];
        int unsigned       lo [NUM_AXES];
        int unsigned       hi [NUM_AXES];
        logic [W_W-1:0]    w_up [NUM_AXES];
        logic [W_W-1:0]    w_dn [NUM_AXES];
        logic [32:0]       d;
        logic [63:0]       p;
        int unsigned       sz;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        clip = 1'b0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            sz = axis_extent(k);
            d = {c[k][DATA_W-1], c[k]} - {origin_q[k][DATA_W-1], origin_q[k]};
            lo[k] = 0;
            w_up[k] = '0;
            if (d[32])
            begin
                // below the origin: a zero step maps to cell 0 without a flag
                if (inv_step_q[k] != '0)
                    clip = 1'b1;
            end
            else
            begin
                p = {32'b0, d[31:0]} * {32'b0, inv_step_q[k]};
                if (p[63:32] >= sz)
                begin
                    clip = 1'b1;
                    lo[k] = sz - 1;
                end
                else
                begin
                    lo[k] = p[63:32];
                    w_up[k] = {1'b0, p[31:16]};
                end
            end
            hi[k] = (lo[k] + 1 < sz) ? lo[k] + 1 : sz - 1;
            w_dn[k] = ONE_Q16 - w_up[k];
        end
        for (int n = 0; n < CORNERS; n++)
        begin
            addr[n] = grid_index(n[0] ? hi[0] : lo[0], n[1] ? hi[1] : lo[1],
                                 n[2] ? hi[2] : lo[2]);
            wt[n] = 64'(n[0] ? w_up[0] : w_dn[0]) * 64'(n[1] ? w_up[1] : w_dn[1])
                  * 64'(n[2] ? w_up[2] : w_dn[2]);
        end
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [DATA_W-1:0] cx, cy, cz);
        logic [ADDR_W-1:0] addr [CORNERS];
        logic [63:0]       wt [CORNERS];
        bit                clip;
        logic [95:0]       acc;
        logic [95:0]       rounded;
        lookup_result_t    res;
        map_query(cx, cy, cz, addr, wt, clip);
        acc = '0;
        // blend offset-binary values so the sum stays unsigned
        for (int n = 0; n < CORNERS; n++)
            acc += {64'b0, grid_model[addr[n]] ^ 32'h8000_0000} * {32'b0, wt[n]};
        rounded = (acc + (96'd1 << 47)) >> 48;
        res.interp = rounded[DATA_W-1:0] ^ 32'h8000_0000;
        res.clip = clip;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 19))
            0, 1:    return 32'h7FFF_FFFF;
            2, 3:    return 32'h8000_0000;
            4:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_origin();
        case ($urandom_range(0, 6))
            0:       return 32'h0;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_inv_step();
        case ($urandom_range(0, 11))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'h0001_0000;
            4:       return 32'h0000_8000;
            5:       return 32'h0002_0000;
            default: return 32'($urandom_range(32'h1000, 32'h8_0000));
        endcase
    endfunction

    function automatic int unsigned pick_base(input int k);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return axis_extent(k) - 4;
            default: return $urandom_range(0, axis_extent(k) - 4);
        endcase
    endfunction

    // coordinate that lands in a 4-cell window from base, now and then outside the grid
    function automatic logic [DATA_W-1:0] window_coord(input int k, input int unsigned base);
        logic [63:0] pos;
        logic [63:0] d;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return origin_q[k] - 32'($urandom_range(1, 1 << 20));
        if (pick == 1)
            pos = {32'(axis_extent(k) + $urandom_range(0, 3)), $urandom};
        else
            pos = {32'(base + $urandom_range(0, 3)),
                   ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom};
        if (inv_step_q[k] == '0)
            d = 64'($urandom_range(0, 1 << 20));
        else
            d = pos / {32'b0, inv_step_q[k]};
        if (d[63:32] != '0)
            d = 64'hFFFF_FFFF;
        return origin_q[k] + d[31:0];
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input cmd_t op, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] v, x, y, z);
        int gap;
        in_valid <= 1'b1;
        cmd <= op;
        entry_address <= a;
        entry_value <= v;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (op == CMD_WRITE)
        begin
            grid_model[a] = v;
            written[a] = 1'b1;
        end
        else
            expected_lookups.push_back(predict_lookup(x, y, z));
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // load any corner the lookup would read before it was ever written
    task automatic ask_query(input logic [DATA_W-1:0] x, y, z);
        logic [ADDR_W-1:0] corner_addr [CORNERS];
        logic [63:0]       corner_wt [CORNERS];
        bit                clip;
        map_query(x, y, z, corner_addr, corner_wt, clip);
        for (int n = 0; n < CORNERS; n++)
            if (!written[corner_addr[n]])
                send_item(CMD_WRITE, corner_addr[n], rand_value(), $urandom, $urandom,
                          $urandom);
        send_item(CMD_QUERY, ADDR_W'($urandom), $urandom, x, y, z);
    endtask

    task automatic load_entry(input int unsigned x, y, z, input logic [DATA_W-1:0] v);
        send_item(CMD_WRITE, grid_index(x, y, z), v, $urandom, $urandom, $urandom);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data <= data;
        @(posedge clk);
        case (r)
            REG_ORIGIN_X:   origin_q[AXIS_X] = data;
            REG_ORIGIN_Y:   origin_q[AXIS_Y] = data;
            REG_ORIGIN_Z:   origin_q[AXIS_Z] = data;
            REG_INV_STEP_X: inv_step_q[AXIS_X] = data;
            REG_INV_STEP_Y: inv_step_q[AXIS_Y] = data;
            REG_INV_STEP_Z: inv_step_q[AXIS_Z] = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] ox, oy, oz, ix, iy, iz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_STEP_X, ix);
        write_reg(REG_INV_STEP_Y, iy);
        write_reg(REG_INV_STEP_Z, iz);
        cfg_wr_en <= 1'b0;
    endtask

    // a load leaves no result behind, so give the block its latency once the queue drains
    task automatic wait_idle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_lookups.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver and result check
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_served)
            begin
                hold_served = hold_token;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                n = pick_gap();
                if (n == 0)
                    n = 1;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        lookup_result_t oldest;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_lookups.size() == 0)
                report_mismatch("result with no lookup pending", value, '0);
            else
            begin
                oldest = expected_lookups.pop_front();
                if (value !== oldest.interp)
                    report_mismatch("value", value, oldest.interp);
                if (clamped !== oldest.clip)
                    report_mismatch("clamped", 32'(clamped), 32'(oldest.clip));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // register reset values: origin 0, step 1.0
        load_entry(0, 0, 0, 32'h7FFF_FFFF);
        load_entry(GX - 1, GY - 1, GZ - 1, 32'h8000_0000);
        ask_query(32'h0, 32'h0, 32'h0);
        ask_query(32'h001F_0000, 32'h001F_0000, 32'h001F_0000);
        // last cell with a fraction: upper corner folds onto the lower one
        ask_query(32'h001F_8000, 32'h001F_8000, 32'h001F_8000);
        ask_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        ask_query(32'h0020_0000, 32'h0, 32'h0);
        ask_query(32'hFFFF_0000, 32'h0, 32'h0);
        ask_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_4000);
    endtask

    task automatic test_rounding_halves();
        // exact half lsb rounds up for both signs
        load_entry(2, 0, 0, 32'h0);
        load_entry(3, 0, 0, 32'h1);
        load_entry(4, 0, 0, 32'hFFFF_FFFF);
        load_entry(5, 0, 0, 32'h0);
        ask_query(32'h0002_8000, 32'h0, 32'h0);
        ask_query(32'h0004_8000, 32'h0, 32'h0);
        // full-scale cube must blend back to full scale
        for (int n = 0; n < CORNERS; n++)
            load_entry(8 + n[0], 8 + n[1], 8 + n[2], 32'h7FFF_FFFF);
        ask_query(32'h0008_4CCD, 32'h0008_B333, 32'h0008_199A);
    endtask

    task automatic test_config_extremes();
        wait_idle();
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                      32'h0001_0000);
        ask_query(32'h7FFF_FFFF, 32'h1234_5678, 32'h0005_0000);
        ask_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0005_8000);
        ask_query(32'h8000_0010, 32'h8000_0000, 32'h0003_0000);
        wait_idle();
        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h0000_8000,
                      32'hFFFF_FFFF, 32'h0);
        ask_query(32'h8000_0000, 32'h8000_0005, 32'hFFFE_0000);
        ask_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0040_0000);
        wait_idle();
        apply_setting(ORIGIN_RESET, ORIGIN_RESET, ORIGIN_RESET, INV_STEP_RESET,
                      INV_STEP_RESET, INV_STEP_RESET);
        ask_query(32'h0001_2000, 32'h0003_C000, 32'h0002_0001);
    endtask

    task automatic test_random_lookups(input int count);
        int unsigned base [NUM_AXES];
        int          target;
        int          pick;
        wait_idle();
        apply_setting(rand_origin(), rand_origin(), rand_origin(), rand_inv_step(),
                      rand_inv_step(), rand_inv_step());
        for (int k = 0; k < NUM_AXES; k++)
            base[k] = pick_base(k);
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_item(CMD_WRITE, ADDR_W'($urandom), rand_value(), $urandom, $urandom,
                          $urandom);
            else if (pick < 18)
                load_entry(base[0] + $urandom_range(0, 3), base[1] + $urandom_range(0, 3),
                           base[2] + $urandom_range(0, 3), rand_value());
            else if (pick < 26)
                ask_query($urandom, $urandom, $urandom);
            else
                ask_query(window_coord(0, base[0]), window_coord(1, base[1]),
                          window_coord(2, base[2]));
        end
    endtask

    task automatic test_backpressure();
        int unsigned base [NUM_AXES];
        wait_idle();
        for (int k = 0; k < NUM_AXES; k++)
            base[k] = pick_base(k);
        idle_on <= 1'b0;
        hold_token <= hold_token + 1;
        repeat (40)
            ask_query(window_coord(0, base[0]), window_coord(1, base[1]),
                      window_coord(2, base[2]));
        idle_on <= 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_WRITE;
        entry_address = '0;
        entry_value = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            origin_q[k] = ORIGIN_RESET;
            inv_step_q[k] = INV_STEP_RESET;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_rounding_halves();
        test_config_extremes();
        repeat (5)
            test_random_lookups(220);
        test_backpressure();
        test_random_lookups(150);

        wait_idle();
        if (expected_lookups.size() != 0)
            report_mismatch("lookups never returned", expected_lookups.size(), '0);
        if (mismatch_count == 0)
            $display("grid_trilinear_interpolator_top_tb: clean");
        else
            $display("grid_trilinear_interpolator_top_tb: errors");
        $finish;
    end

endmodule
